// ===== rtl/mtcp_pkg.sv =====
package mtcp_pkg;

    localparam int VarlenMaxBytes = 4;

    // result kinds
    localparam logic [1:0] KIND_CHANNEL = 2'd0;
    localparam logic [1:0] KIND_TEMPO   = 2'd1;
    localparam logic [1:0] KIND_EOT     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NAME     = 3'd0;
    localparam logic [2:0] ERR_PAST_END = 3'd1;
    localparam logic [2:0] ERR_VARLEN   = 3'd2;
    localparam logic [2:0] ERR_NO_RS    = 3'd3;
    localparam logic [2:0] ERR_STATUS   = 3'd4;
    localparam logic [2:0] ERR_TEMPO    = 3'd5;
    localparam logic [2:0] ERR_TIMESIG  = 3'd6;

    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  message_type;
        logic [3:0]  channel;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [31:0] tick;
        logic [23:0] tempo_us;
        logic [2:0]  error_code;
    } t_result;

    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h4D;
            2'd1:    v = 8'h54;
            2'd2:    v = 8'h72;
            default: v = 8'h6B;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/mtcp_if.sv =====
interface mtcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface mtcp_out_if;
    import mtcp_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/midi_track_chunk_parser_unit.sv =====
// Channel   Dir  Beat
// i_in      in   one track byte
// o_out     out  one result (message, tempo, end of track, error)
// One byte per cycle while the queue has room; the parser updates its state in
// the cycle of acceptance. A result is registered, then enters a two-entry
// queue the next cycle, from which it is offered on o_out.
// A byte is taken while the queue holds at most one result, counting the one
// being pushed; a stalled sink blocks input after at most two results. With the
// sink ready, bytes flow every cycle, except for a stall when two bytes in a
// row both give results.
// Reset is synchronous; no clearing pass.
module midi_track_chunk_parser_unit #(
    parameter int VARLEN_MAX_BYTES = mtcp_pkg::VarlenMaxBytes
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mtcp_in_if.sink    i_in,
    mtcp_out_if.source o_out
);
    import mtcp_pkg::*;

    logic    take, res_valid, space;
    t_result res;

    // queue plus the result being pushed leaves an entry for this byte's result
    assign i_in.ready = space;
    assign take = i_in.valid && i_in.ready;

    mtcp_front #(.VARLEN_MAX_BYTES(VARLEN_MAX_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_byte(i_in.data_byte),
        .o_res_valid(res_valid), .o_res(res)
    );

    mtcp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(res_valid), .i_data(res),
        .o_space(space), .o_out(o_out)
    );
endmodule

// ===== rtl/mtcp_front.sv =====
// Parsing engine: one byte per beat, yields at most one result per byte
module mtcp_front #(
    parameter int VARLEN_MAX_BYTES = mtcp_pkg::VarlenMaxBytes
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output mtcp_pkg::t_result o_res
);
    import mtcp_pkg::*;

    localparam int CntW = $clog2(VARLEN_MAX_BYTES + 1);

    typedef enum logic [3:0] {
        PH_NAME, PH_LEN, PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
        PH_META_TYPE, PH_META_LEN, PH_META_DATA, PH_SYSEX_LEN,
        PH_SYSEX_DATA, PH_TRAILER, PH_DEAD
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_left, n_left;
    logic [31:0] r_tick, n_tick;
    logic [7:0]  r_rs, n_rs;
    logic [7:0]  r_cur, n_cur;
    logic [31:0] r_vl, n_vl;
    logic [CntW-1:0] r_vcnt, n_vcnt;
    logic [7:0]  r_held, n_held;
    logic [7:0]  r_meta, n_meta;
    logic [31:0] r_skip, n_skip;
    logic [23:0] r_tshift, n_tshift;
    logic [1:0]  r_hidx, n_hidx;
    logic        n_rv;
    t_result     n_res;

    logic [31:0] vl_next;
    logic        vl_long, left_zero;
    logic [3:0]  ctype;

    assign vl_next   = {r_vl[24:0], i_byte[6:0]};
    assign vl_long   = (32'(r_vcnt) >= 32'(VARLEN_MAX_BYTES));
    assign left_zero = (r_left == '0);

    always_comb begin
        t_result res;
        logic    done;
        logic [31:0] tsh;
        n_phase = r_phase; n_left = r_left; n_tick = r_tick; n_rs = r_rs;
        n_cur = r_cur; n_vl = r_vl; n_vcnt = r_vcnt; n_held = r_held;
        n_meta = r_meta; n_skip = r_skip; n_tshift = r_tshift; n_hidx = r_hidx;
        res = '0;
        n_rv = 1'b0;
        done = 1'b0;
        tsh = {8'd0, r_tshift};
        ctype = 4'd0;
        if (i_take) begin
            case (r_phase)
                PH_NAME: begin
                    if (i_byte != tag_byte(r_hidx)) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NAME;
                        n_phase = PH_DEAD;
                    end else begin
                        n_hidx = r_hidx + 2'd1;
                        if (r_hidx == 2'd3) begin
                            n_left = '0; n_phase = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    n_left = {r_left[23:0], i_byte};
                    n_hidx = r_hidx + 2'd1;
                    if (r_hidx == 2'd3) begin
                        n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                    end
                end
                PH_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
                    if (vl_long || left_zero) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = vl_long ? ERR_VARLEN : ERR_PAST_END;
                        n_phase = PH_DEAD;
                    end else begin
                        n_left = r_left - 32'd1;
                        n_vcnt = r_vcnt + CntW'(1);
                        n_vl = vl_next;
                        if (!i_byte[7]) begin
                            if (r_phase == PH_DELTA) begin
                                n_tick = r_tick + vl_next;
                                n_phase = PH_STATUS;
                            end else if (vl_next > r_left - 32'd1) begin
                                n_rv = 1'b1; res.kind = KIND_ERROR;
                                res.error_code = ERR_PAST_END; n_phase = PH_DEAD;
                            end else begin
                                n_skip = vl_next;
                                if (r_phase == PH_META_LEN) begin
                                    n_tshift = '0; tsh = '0;
                                    if (vl_next == '0) done = 1'b1;
                                    else n_phase = PH_META_DATA;
                                end else if (vl_next == '0) begin
                                    n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                                end else n_phase = PH_SYSEX_DATA;
                            end
                        end
                    end
                end
                PH_STATUS, PH_DATA1: begin
                    if (left_zero) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_PAST_END; n_phase = PH_DEAD;
                    end else if (r_phase == PH_STATUS && i_byte[7]) begin
                        n_left = r_left - 32'd1;
                        if (i_byte < 8'hF8) n_rs = (i_byte < 8'hF0) ? i_byte : 8'd0;
                        n_cur = i_byte;
                        if (i_byte == 8'hFF) n_phase = PH_META_TYPE;
                        else if (i_byte == 8'hF0 || i_byte == 8'hF7) begin
                            n_vl = '0; n_vcnt = '0; n_phase = PH_SYSEX_LEN;
                        end else n_phase = PH_DATA1;
                    end else if (r_phase == PH_STATUS && r_rs == 8'd0) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_NO_RS; n_phase = PH_DEAD;
                    end else begin
                        // first data byte, status from running status if needed
                        if (r_phase == PH_STATUS) n_cur = r_rs;
                        ctype = (r_phase == PH_STATUS) ? r_rs[7:4] : r_cur[7:4];
                        n_left = r_left - 32'd1;
                        if (ctype < 4'd8 || ctype > 4'd14) begin
                            n_rv = 1'b1; res.kind = KIND_ERROR;
                            res.error_code = ERR_STATUS; n_phase = PH_DEAD;
                        end else begin
                            n_held = i_byte;
                            if (ctype == 4'd12 || ctype == 4'd13) begin
                                n_rv = 1'b1; res.kind = KIND_CHANNEL;
                                res.message_type = ctype;
                                res.channel = (r_phase == PH_STATUS) ? r_rs[3:0] : r_cur[3:0];
                                res.first_data = i_byte; res.tick = r_tick;
                                n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                            end else n_phase = PH_DATA2;
                        end
                    end
                end
                PH_DATA2: begin
                    if (left_zero) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_PAST_END; n_phase = PH_DEAD;
                    end else begin
                        n_left = r_left - 32'd1;
                        n_rv = 1'b1; res.kind = KIND_CHANNEL;
                        res.message_type = r_cur[7:4]; res.channel = r_cur[3:0];
                        res.first_data = r_held; res.second_data = i_byte;
                        res.tick = r_tick;
                        n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                    end
                end
                PH_META_TYPE: begin
                    if (left_zero) begin
                        n_rv = 1'b1; res.kind = KIND_ERROR;
                        res.error_code = ERR_PAST_END; n_phase = PH_DEAD;
                    end else begin
                        n_left = r_left - 32'd1; n_meta = i_byte;
                        n_vl = '0; n_vcnt = '0; n_phase = PH_META_LEN;
                    end
                end
                PH_META_DATA: begin
                    if (!left_zero) n_left = r_left - 32'd1;
                    n_tshift = {r_tshift[15:0], i_byte};
                    tsh = {8'd0, r_tshift[15:0], i_byte};
                    if (r_skip != '0) n_skip = r_skip - 32'd1;
                    if (r_skip <= 32'd1) done = 1'b1;
                end
                PH_SYSEX_DATA: begin
                    if (!left_zero) n_left = r_left - 32'd1;
                    if (r_skip != '0) n_skip = r_skip - 32'd1;
                    if (r_skip <= 32'd1) begin
                        n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                    end
                end
                PH_TRAILER: begin
                    if (!left_zero) n_left = r_left - 32'd1;
                    if (r_left <= 32'd1) begin
                        n_phase = PH_NAME; n_hidx = '0; n_left = '0;
                        n_tick = '0; n_rs = '0;
                    end
                end
                default: ;
            endcase
            // end of a meta event; n_vl holds its length in both entry paths
            if (done) begin
                if (r_meta == META_EOT) begin
                    n_rv = 1'b1; res = '0; res.kind = KIND_EOT; res.tick = r_tick;
                    if (n_left != '0) n_phase = PH_TRAILER;
                    else begin
                        n_phase = PH_NAME; n_hidx = '0; n_left = '0;
                        n_tick = '0; n_rs = '0;
                    end
                end else if (r_meta == META_TEMPO) begin
                    n_rv = 1'b1; res = '0;
                    if (n_vl != 32'd3) begin
                        res.kind = KIND_ERROR; res.error_code = ERR_TEMPO;
                        n_phase = PH_DEAD;
                    end else begin
                        res.kind = KIND_TEMPO; res.tick = r_tick;
                        res.tempo_us = tsh[23:0];
                        n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                    end
                end else if (r_meta == META_TIMESIG && n_vl != 32'd4) begin
                    n_rv = 1'b1; res = '0; res.kind = KIND_ERROR;
                    res.error_code = ERR_TIMESIG; n_phase = PH_DEAD;
                end else begin
                    n_vl = '0; n_vcnt = '0; n_phase = PH_DELTA;
                end
            end
        end
        n_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME; r_left <= '0; r_tick <= '0; r_rs <= '0;
            r_cur <= '0; r_vl <= '0; r_vcnt <= '0; r_held <= '0; r_meta <= '0;
            r_skip <= '0; r_tshift <= '0; r_hidx <= '0; o_res_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_left <= n_left; r_tick <= n_tick; r_rs <= n_rs;
            r_cur <= n_cur; r_vl <= n_vl; r_vcnt <= n_vcnt; r_held <= n_held;
            r_meta <= n_meta; r_skip <= n_skip; r_tshift <= n_tshift;
            r_hidx <= n_hidx; o_res_valid <= n_rv;
        end
        o_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DEAD |=> r_phase == PH_DEAD)
        else $error("left dead state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == KIND_ERROR |-> r_phase == PH_DEAD)
        else $error("error without dead state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_take) |-> !o_res_valid)
        else $error("result without byte");
endmodule

// ===== rtl/mtcp_queue.sv =====
// Result queue between parser and output; two entries
module mtcp_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  mtcp_pkg::t_result i_data,
    output logic o_space,
    mtcp_out_if.source o_out
);
    import mtcp_pkg::*;

    t_result    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       pop;

    assign pop         = o_out.valid && o_out.ready;
    assign o_out.valid = (r_cnt != 2'd0);
    assign o_out.payload = r_mem[r_rp];
    // room for one more result once the one being pushed is counted
    assign o_space     = (r_cnt == 2'd0) || (r_cnt == 2'd1 && !i_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overrun");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !i_push) else $error("push into full queue");
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mtcp_pkg::*;

    // parse phases of the track predictor
    typedef enum logic [3:0] {
        P_NAME, P_LEN, P_DELTA, P_STATUS, P_DATA1, P_DATA2, P_META_TYPE, P_META_LEN,
        P_META_DATA, P_SYSEX_LEN, P_SYSEX_DATA, P_TRAILER, P_DEAD
    } t_phase;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk;
    logic i_rst_n;

    mtcp_in_if  in_ch ();
    mtcp_out_if out_ch ();

    midi_track_chunk_parser_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // track predictor state
    t_phase      ph;
    logic [31:0] left_cnt;
    logic [31:0] tick_cnt;
    logic [7:0]  run_stat;
    logic [7:0]  cur_stat;
    logic [31:0] vl_val;
    logic [2:0]  vl_cnt;
    logic [7:0]  held;
    logic [7:0]  meta_id;
    logic [31:0] skip_left;
    logic [23:0] tempo_acc;
    logic [2:0]  name_idx;

    logic [7:0] pending_bytes[$];
    t_result    expected_results[$];
    int         n_errors;
    int         cycles;
    bit         quiet;    // no idling in the last part
    bit         hold_in;  // sender hold-off until drained
    bit         held_once;
    bit         feed_done;

    function automatic void expect_result(t_result r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void queue_byte(logic [7:0] v);
        pending_bytes.insert(pending_bytes.size(), v);
    endfunction

    function automatic void fresh_chunk();
        ph = P_NAME;
        name_idx = 0;
        left_cnt = 0;
        tick_cnt = 0;
        run_stat = 0;
    endfunction

    function automatic void begin_varlen(t_phase nxt);
        vl_val = 0;
        vl_cnt = 0;
        ph = nxt;
    endfunction

    function automatic void push_error(logic [2:0] code);
        t_result r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        expect_result(r);
        ph = P_DEAD;
    endfunction

    function automatic void push_channel(logic [7:0] second);
        t_result r;
        r = '0;
        r.kind = KIND_CHANNEL;
        r.message_type = cur_stat[7:4];
        r.channel = cur_stat[3:0];
        r.first_data = held;
        r.second_data = second;
        r.tick = tick_cnt;
        expect_result(r);
        begin_varlen(P_DELTA);
    endfunction

    // -1 error (code in err), 0 more bytes, 1 done
    function automatic int varlen_take(logic [7:0] b, output logic [2:0] err);
        err = 0;
        if (vl_cnt >= VarlenMaxBytes) begin
            err = ERR_VARLEN;
            return -1;
        end
        if (left_cnt == 0) begin
            err = ERR_PAST_END;
            return -1;
        end
        left_cnt--;
        vl_cnt++;
        vl_val = (vl_val << 7) | 32'(b[6:0]);
        return b[7] ? 0 : 1;
    endfunction

    function automatic void first_data_take(logic [7:0] b);
        if (left_cnt == 0) begin
            push_error(ERR_PAST_END);
            return;
        end
        left_cnt--;
        if (cur_stat[7:4] < 4'd8 || cur_stat[7:4] > 4'd14) begin
            push_error(ERR_STATUS);
            return;
        end
        held = b;
        if (cur_stat[7:4] == 4'd12 || cur_stat[7:4] == 4'd13) push_channel(8'h00);
        else ph = P_DATA2;
    endfunction

    function automatic void meta_done();
        t_result r;
        r = '0;
        if (meta_id == META_EOT) begin
            r.kind = KIND_EOT;
            r.tick = tick_cnt;
            expect_result(r);
            if (left_cnt > 0) ph = P_TRAILER;
            else fresh_chunk();
        end else if (meta_id == META_TEMPO) begin
            if (vl_val != 3) begin
                push_error(ERR_TEMPO);
                return;
            end
            r.kind = KIND_TEMPO;
            r.tick = tick_cnt;
            r.tempo_us = tempo_acc;
            expect_result(r);
            begin_varlen(P_DELTA);
        end else if (meta_id == META_TIMESIG && vl_val != 4) begin
            push_error(ERR_TIMESIG);
        end else begin
            begin_varlen(P_DELTA);
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [2:0] err;
        int r;
        case (ph)
            P_NAME: begin
                if (b != tag_byte(name_idx[1:0])) push_error(ERR_NAME);
                else begin
                    name_idx++;
                    if (name_idx >= 4) begin
                        name_idx = 0;
                        left_cnt = 0;
                        ph = P_LEN;
                    end
                end
            end
            P_LEN: begin
                left_cnt = (left_cnt << 8) | 32'(b);
                name_idx++;
                if (name_idx >= 4) begin
                    name_idx = 0;
                    begin_varlen(P_DELTA);
                end
            end
            P_DELTA: begin
                r = varlen_take(b, err);
                if (r < 0) push_error(err);
                else if (r > 0) begin
                    tick_cnt += vl_val;
                    ph = P_STATUS;
                end
            end
            P_STATUS: begin
                if (left_cnt == 0) push_error(ERR_PAST_END);
                else if (b[7]) begin
                    left_cnt--;
                    if (b < 8'hF8) run_stat = (b < 8'hF0) ? b : 8'h00;
                    cur_stat = b;
                    if (b == 8'hFF) ph = P_META_TYPE;
                    else if (b == 8'hF0 || b == 8'hF7) begin_varlen(P_SYSEX_LEN);
                    else ph = P_DATA1;
                end else if (run_stat == 0) push_error(ERR_NO_RS);
                else begin
                    cur_stat = run_stat;
                    first_data_take(b);
                end
            end
            P_DATA1: first_data_take(b);
            P_DATA2: begin
                if (left_cnt == 0) push_error(ERR_PAST_END);
                else begin
                    left_cnt--;
                    push_channel(b);
                end
            end
            P_META_TYPE: begin
                if (left_cnt == 0) push_error(ERR_PAST_END);
                else begin
                    left_cnt--;
                    meta_id = b;
                    begin_varlen(P_META_LEN);
                end
            end
            P_META_LEN, P_SYSEX_LEN: begin
                r = varlen_take(b, err);
                if (r < 0) push_error(err);
                else if (r > 0) begin
                    if (vl_val > left_cnt) push_error(ERR_PAST_END);
                    else begin
                        skip_left = vl_val;
                        if (ph == P_META_LEN) begin
                            tempo_acc = 0;
                            if (skip_left == 0) meta_done();
                            else ph = P_META_DATA;
                        end else if (skip_left == 0) begin_varlen(P_DELTA);
                        else ph = P_SYSEX_DATA;
                    end
                end
            end
            P_META_DATA: begin
                if (left_cnt > 0) left_cnt--;
                tempo_acc = {tempo_acc[15:0], b};
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) meta_done();
            end
            P_SYSEX_DATA: begin
                if (left_cnt > 0) left_cnt--;
                if (skip_left > 0) skip_left--;
                if (skip_left == 0) begin_varlen(P_DELTA);
            end
            P_TRAILER: begin
                if (left_cnt > 0) left_cnt--;
                if (left_cnt == 0) fresh_chunk();
            end
            default: ;
        endcase
    endfunction

    // ---- stimulus builders: chunk body collected then wrapped ----
    logic [7:0] body[$];
    logic [7:0] rs_val;  // running status live in the chunk being built
    logic [7:0] tag_bytes[4] = '{8'h4D, 8'h54, 8'h72, 8'h6B};

    function automatic void add_byte(logic [7:0] v);
        body.insert(body.size(), v);
    endfunction

    function automatic void put_varlen(logic [31:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            add_byte({(i != 0), 7'((v >> (7 * i)) & 32'h7F)});
    endfunction

    function automatic void put_delta();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 1;
        put_varlen($urandom, n);
    endfunction

    function automatic void put_event();
        int k;
        logic [7:0] st;
        k = $urandom_range(0, 17);
        put_delta();
        if (k < 10) begin
            st = 8'($urandom_range(8'h80, 8'hEF));
            if (k > 7 && rs_val != 8'h00) begin
                // running status: no status byte, first data must look like data
                st = rs_val;
                add_byte(8'($urandom) & 8'h7F);
            end else begin
                add_byte(st);
                rs_val = st;
                add_byte(8'($urandom));
            end
            if (st[7:4] != 4'hC && st[7:4] != 4'hD) add_byte(8'($urandom));
        end else if (k < 13) begin
            add_byte(8'hFF);
            add_byte(META_TEMPO);
            add_byte(8'h03);
            repeat (3) add_byte(8'($urandom));
        end else if (k < 15) begin
            add_byte(8'hFF);
            add_byte(($urandom_range(0, 1) != 0) ? META_TIMESIG : 8'($urandom_range(0, 8'h50)));
            add_byte(8'h04);
            repeat (4) add_byte(8'($urandom));
        end else if (k < 17) begin
            add_byte(($urandom_range(0, 1) != 0) ? 8'hF0 : 8'hF7);
            rs_val = 8'h00;
            k = $urandom_range(0, 3);
            add_byte(8'(k));
            repeat (k) add_byte(8'($urandom));
        end else begin
            // empty text meta event
            add_byte(8'hFF);
            add_byte(8'h01);
            add_byte(8'h00);
        end
    endfunction

    // wraps body into a chunk; mode 0 exact, 1 with trailer, 2 length moved by up to two either way
    task automatic emit_chunk(int mode);
        logic [31:0] len;
        len = 32'(body.size());
        if (mode == 1) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        len = (mode == 2) ? len + 32'($urandom_range(0, 4)) - 32'd2 : 32'(body.size());
        foreach (tag_bytes[i]) queue_byte(tag_bytes[i]);
        for (int i = 3; i >= 0; i--) queue_byte(len[8*i +: 8]);
        foreach (body[i]) queue_byte(body[i]);
        body.delete();
        rs_val = 8'h00;
    endtask

    task automatic put_eot();
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(META_EOT);
        add_byte(8'h00);
    endtask

    task automatic reset_block();
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // ---- acceptance and prediction at the rising edge ----
    bit in_taken;
    always @(posedge i_clk) begin
        in_taken = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_taken) parse_byte(in_ch.data_byte);
    end

    // ---- driver ----
    int in_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                in_gap = $urandom_range(0, 3);
                in_ch.valid <= 1'b0;
            end else if (pending_bytes.size() != 0 && !hold_in) begin
                in_ch.valid <= 1'b1;
                in_ch.data_byte <= pending_bytes.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // sink stall bursts
    int out_gap;
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_gap = $urandom_range(0, 3);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.message_type !== want.message_type
                    || got.channel !== want.channel || got.first_data !== want.first_data
                    || got.second_data !== want.second_data || got.tick !== want.tick
                    || got.tempo_us !== want.tempo_us
                    || got.error_code !== want.error_code) begin
                    n_errors++;
                    $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
                end
            end
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // one track run: a few chunks of random events; error at the end optional
    task automatic random_track(int n_chunks);
        for (int c = 0; c < n_chunks; c++) begin
            repeat ($urandom_range(1, 12)) put_event();
            put_eot();
            emit_chunk(($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 1));
        end
        // occasional corrupted stream
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom));
    endtask

    task automatic run_and_reset_state();
        wait_drained();
    endtask

    initial begin
        int fed;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'h00;
        out_ch.ready = 1'b0;
        n_errors = 0;
        cycles = 0;
        quiet = 0;
        hold_in = 0;
        held_once = 0;
        in_gap = 0;
        out_gap = 0;
        rs_val = 8'h00;
        fresh_chunk();
        cur_stat = 0;
        vl_val = 0;
        vl_cnt = 0;
        held = 0;
        meta_id = 0;
        skip_left = 0;
        tempo_acc = 0;
        reset_block();

        // directed: extremes, note off and program change, tempo of zero and maximum
        body = {body, 8'h00, 8'h80, 8'h00, 8'hFF};   // note off, extreme data
        body = {body, 8'hFF, 8'hFF, 8'hFF, 8'h7F};   // max delta
        body = {body, 8'h7F, 8'h00};                 // running
        body = {body, 8'h00, 8'hCF, 8'hAA};
        body = {body, 8'h00, 8'hFF, META_TEMPO, 8'h03, 8'h00, 8'h00, 8'h00};
        put_eot();
        emit_chunk(0);
        wait_drained();
        body = {body, 8'h00, 8'hFF, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF};
        put_eot();
        emit_chunk(1);

        // random tracks; once the sender holds off until all results are in.
        // An error leaves the block silent until reset, and reset stays single,
        // so broken streams are placed only at the end of the run.
        fed = 0;
        while (fed < 260) begin
            int before_sz;
            before_sz = pending_bytes.size();
            repeat ($urandom_range(1, 12)) put_event();
            put_eot();
            emit_chunk($urandom_range(0, 1));
            fed += pending_bytes.size() - before_sz;
            if (fed > 150 && !held_once) begin
                held_once = 1;
                hold_in = 1;
                while (expected_results.size() != 0 || in_ch.valid) @(posedge i_clk);
                hold_in = 0;
            end
            while (pending_bytes.size() > 40) @(posedge i_clk);
        end
        quiet = 1;
        // final stream: two random chunks, possibly with a bad length, optional noise, then a zero byte
        random_track(2);
        queue_byte(8'h00);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
